FILE: hdl/gcr_pkg.sv
// shared constants and modular helpers for the garner crt reconstruction unit
`timescale 1ns / 1ps
package gcr_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned LIMB_W  = 64;
  localparam int unsigned VALUE_W = 4 * LIMB_W;

  localparam logic [2:0] REG_MODULUS_0    = 3'd0;
  localparam logic [2:0] REG_MODULUS_1    = 3'd1;
  localparam logic [2:0] REG_MODULUS_2    = 3'd2;
  localparam logic [2:0] REG_INV_PREFIX_1 = 3'd3;
  localparam logic [2:0] REG_INV_PREFIX_2 = 3'd4;

  // operands below m
  function automatic logic [WORD_W-1:0] add_m(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] m);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_W-1:0];
  endfunction

  // operands below m
  function automatic logic [WORD_W-1:0] sub_m(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (m - b);
    end
    return r;
  endfunction

endpackage

FILE: hdl/gcr_modred.sv
// pipelined restoring reduction a mod m, one bit per stage
`timescale 1ns / 1ps
module gcr_modred #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [gcr_pkg::WORD_W-1:0] a_i,
  input  logic [gcr_pkg::WORD_W-1:0] m_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic [gcr_pkg::WORD_W-1:0] r_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned W = gcr_pkg::WORD_W;

  logic [W-1:0]      rem_q  [W];
  logic [W-1:0]      src_q  [W];
  logic [SIDE_W-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]      rem_in;
    logic [W-1:0]      src_in;
    logic [SIDE_W-1:0] side_in;
    logic [W:0]        t;
    logic [W-1:0]      rem_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign src_in  = a_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign src_in  = src_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      t = {rem_in, src_in[W-1]};
      if (t >= {1'b0, m_i}) begin
        t = t - {1'b0, m_i};
      end
      rem_d = t[W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        src_q[k]  <= {src_in[W-2:0], 1'b0};
        side_q[k] <= side_in;
      end
    end
  end

  assign r_o    = (m_i == '0) ? '0 : rem_q[W-1];
  assign side_o = side_q[W-1];

endmodule

FILE: hdl/gcr_modmul.sv
// pipelined double-and-add modular multiply, one multiplier bit per stage
`timescale 1ns / 1ps
module gcr_modmul #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [gcr_pkg::WORD_W-1:0] a_i,
  input  logic [gcr_pkg::WORD_W-1:0] b_i,
  input  logic [gcr_pkg::WORD_W-1:0] m_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic [gcr_pkg::WORD_W-1:0] p_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned W = gcr_pkg::WORD_W;

  logic [W-1:0]      acc_q  [W];
  logic [W-1:0]      a_q    [W];
  logic [W-1:0]      b_q    [W];
  logic [SIDE_W-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]      acc_in;
    logic [W-1:0]      a_in;
    logic [W-1:0]      b_in;
    logic [SIDE_W-1:0] side_in;
    logic [W-1:0]      dbl;
    logic [W-1:0]      acc_d;

    if (k == 0) begin : g_first
      assign acc_in  = '0;
      assign a_in    = a_i;
      assign b_in    = b_i;
      assign side_in = side_i;
    end else begin : g_next
      assign acc_in  = acc_q[k-1];
      assign a_in    = a_q[k-1];
      assign b_in    = b_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      dbl   = gcr_pkg::add_m(acc_in, acc_in, m_i);
      acc_d = b_in[W-1] ? gcr_pkg::add_m(dbl, a_in, m_i) : dbl;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= acc_d;
        a_q[k]    <= a_in;
        b_q[k]    <= {b_in[W-2:0], 1'b0};
        side_q[k] <= side_in;
      end
    end
  end

  assign p_o    = (m_i < W'(2)) ? '0 : acc_q[W-1];
  assign side_o = side_q[W-1];

endmodule

FILE: hdl/garner_crt_reconstruct_unit.sv
// top level: garner crt reconstruction of three residues into a 256-bit value
// throughput: one item per cycle unless the output stalls; six 64-stage bit-serial chains then 4 wide stages
// the whole pipeline stalls together while a result waits on m_axis_tready
// reset clears all valid bits and loads the register defaults
`timescale 1ns / 1ps
module garner_crt_reconstruct_unit #(
  parameter int unsigned PRIME_COUNT = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // residue_0, residue_1, residue_2, level, zero fill
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value_limb0, value_limb1, value_limb2, value_limb3
  output logic [255:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned W   = gcr_pkg::WORD_W;
  localparam int unsigned LAT = 6 * W + 4;
  localparam int unsigned CAP = (PRIME_COUNT < 3) ? PRIME_COUNT : 3;

  logic [W-1:0] mod0_q, mod1_q, mod2_q, inv1_q, inv2_q;
  logic [2:0]   reg_idx;
  logic         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod0_q <= W'(2);
      mod1_q <= W'(3);
      mod2_q <= W'(5);
      inv1_q <= W'(2);
      inv2_q <= W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        gcr_pkg::REG_MODULUS_0:    mod0_q <= pwdata;
        gcr_pkg::REG_MODULUS_1:    mod1_q <= pwdata;
        gcr_pkg::REG_MODULUS_2:    mod2_q <= pwdata;
        gcr_pkg::REG_INV_PREFIX_1: inv1_q <= pwdata;
        gcr_pkg::REG_INV_PREFIX_2: inv2_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gcr_pkg::REG_MODULUS_0:    prdata = mod0_q;
      gcr_pkg::REG_MODULUS_1:    prdata = mod1_q;
      gcr_pkg::REG_MODULUS_2:    prdata = mod2_q;
      gcr_pkg::REG_INV_PREFIX_1: prdata = inv1_q;
      gcr_pkg::REG_INV_PREFIX_2: prdata = inv2_q;
      default:                   prdata = '0;
    endcase
  end

  // pipeline control
  logic           en;
  logic           s_accept;
  logic [LAT-1:0] vld_q, vld_d;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign vld_d         = {vld_q[LAT-2:0], s_accept};
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  logic [W-1:0] r0, r1, r2;
  logic [1:0]   lvl_in, lvl_c;

  assign r0     = s_axis_tdata[63:0];
  assign r1     = s_axis_tdata[127:64];
  assign r2     = s_axis_tdata[191:128];
  assign lvl_in = s_axis_tdata[193:192];
  assign lvl_c  = (lvl_in > CAP[1:0]) ? CAP[1:0] : lvl_in;

  // first reductions
  logic [W-1:0] a0, a1, a2, i1, i2, c2;
  logic [1:0]   s1_lvl;

  gcr_modred #(.SIDE_W(2)) u_red_a0 (
    .clk_i, .en_i(en), .a_i(r0), .m_i(mod0_q), .side_i(lvl_c), .r_o(a0), .side_o(s1_lvl));
  gcr_modred u_red_a1 (
    .clk_i, .en_i(en), .a_i(r1), .m_i(mod1_q), .side_i(1'b0), .r_o(a1), .side_o());
  gcr_modred u_red_a2 (
    .clk_i, .en_i(en), .a_i(r2), .m_i(mod2_q), .side_i(1'b0), .r_o(a2), .side_o());
  gcr_modred u_red_i1 (
    .clk_i, .en_i(en), .a_i(inv1_q), .m_i(mod1_q), .side_i(1'b0), .r_o(i1), .side_o());
  gcr_modred u_red_i2 (
    .clk_i, .en_i(en), .a_i(inv2_q), .m_i(mod2_q), .side_i(1'b0), .r_o(i2), .side_o());
  gcr_modred u_red_c2 (
    .clk_i, .en_i(en), .a_i(mod0_q), .m_i(mod2_q), .side_i(1'b0), .r_o(c2), .side_o());

  // digit 0 reduced by the other moduli
  localparam int unsigned S2_W = 2 + 6 * W;
  logic [W-1:0] e1, e2;
  logic [W-1:0] s2_a0, s2_a1, s2_a2, s2_i1, s2_i2, s2_c2;
  logic [1:0]   s2_lvl;

  gcr_modred #(.SIDE_W(S2_W)) u_red_e1 (
    .clk_i, .en_i(en), .a_i(a0), .m_i(mod1_q),
    .side_i({s1_lvl, a0, a1, a2, i1, i2, c2}), .r_o(e1),
    .side_o({s2_lvl, s2_a0, s2_a1, s2_a2, s2_i1, s2_i2, s2_c2}));
  gcr_modred u_red_e2 (
    .clk_i, .en_i(en), .a_i(a0), .m_i(mod2_q), .side_i(1'b0), .r_o(e2), .side_o());

  // digit 1
  localparam int unsigned S3_W = 2 + 5 * W;
  logic [W-1:0] diff1, d1;
  logic [W-1:0] s3_a0, s3_a2, s3_i2, s3_c2, s3_e2;
  logic [1:0]   s3_lvl;

  assign diff1 = gcr_pkg::sub_m(s2_a1, e1, mod1_q);

  gcr_modmul #(.SIDE_W(S3_W)) u_mul_d1 (
    .clk_i, .en_i(en), .a_i(diff1), .b_i(s2_i1), .m_i(mod1_q),
    .side_i({s2_lvl, s2_a0, s2_a2, s2_i2, s2_c2, e2}), .p_o(d1),
    .side_o({s3_lvl, s3_a0, s3_a2, s3_i2, s3_c2, s3_e2}));

  // digit 1 modulo q2
  localparam int unsigned S4_W = 2 + 6 * W;
  logic [W-1:0] f1;
  logic [W-1:0] s4_a0, s4_a2, s4_i2, s4_c2, s4_e2, s4_d1;
  logic [1:0]   s4_lvl;

  gcr_modred #(.SIDE_W(S4_W)) u_red_f1 (
    .clk_i, .en_i(en), .a_i(d1), .m_i(mod2_q),
    .side_i({s3_lvl, s3_a0, s3_a2, s3_i2, s3_c2, s3_e2, d1}), .r_o(f1),
    .side_o({s4_lvl, s4_a0, s4_a2, s4_i2, s4_c2, s4_e2, s4_d1}));

  // d1 * q0 mod q2
  localparam int unsigned S5_W = 2 + 5 * W;
  logic [W-1:0] t2;
  logic [W-1:0] s5_a0, s5_a2, s5_i2, s5_e2, s5_d1;
  logic [1:0]   s5_lvl;

  gcr_modmul #(.SIDE_W(S5_W)) u_mul_t2 (
    .clk_i, .en_i(en), .a_i(f1), .b_i(s4_c2), .m_i(mod2_q),
    .side_i({s4_lvl, s4_a0, s4_a2, s4_i2, s4_e2, s4_d1}), .p_o(t2),
    .side_o({s5_lvl, s5_a0, s5_a2, s5_i2, s5_e2, s5_d1}));

  // digit 2
  localparam int unsigned S6_W = 2 + 2 * W;
  logic [W-1:0] part2, diff2, d2;
  logic [W-1:0] s6_a0, s6_d1;
  logic [1:0]   s6_lvl;

  assign part2 = gcr_pkg::add_m(s5_e2, t2, mod2_q);
  assign diff2 = gcr_pkg::sub_m(s5_a2, part2, mod2_q);

  gcr_modmul #(.SIDE_W(S6_W)) u_mul_d2 (
    .clk_i, .en_i(en), .a_i(diff2), .b_i(s5_i2), .m_i(mod2_q),
    .side_i({s5_lvl, s5_a0, s5_d1}), .p_o(d2),
    .side_o({s6_lvl, s6_a0, s6_d1}));

  // mixed radix sum d0 + q0*(d1 + q1*d2)
  logic [W-1:0] d0m, d1m, d2m;

  assign d0m = (s6_lvl != 2'd0) ? s6_a0 : '0;
  assign d1m = (s6_lvl >= 2'd2) ? s6_d1 : '0;
  assign d2m = (s6_lvl == 2'd3) ? d2 : '0;

  logic [63:0]  pa_q [4];
  logic [W-1:0] w1_d0_q, w1_d1_q;
  logic [127:0] y_q;
  logic [W-1:0] w2_d0_q;
  logic [63:0]  pp_q [8];
  logic [W-1:0] w3_d0_q;
  logic [255:0] x_q;
  logic [127:0] y_d;
  logic [255:0] x_d;

  always_comb begin
    y_d = {pa_q[3], 64'd0} + {32'd0, pa_q[2], 32'd0} + {32'd0, pa_q[1], 32'd0}
        + {64'd0, pa_q[0]} + {64'd0, w1_d1_q};
  end

  always_comb begin
    x_d = {192'd0, w3_d0_q};
    for (int n = 0; n < 8; n++) begin
      x_d = x_d + ({192'd0, pp_q[n]} << (32 * ((n / 4) + (n % 4))));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= 64'(mod1_q[31:0])  * 64'(d2m[31:0]);
      pa_q[1] <= 64'(mod1_q[31:0])  * 64'(d2m[63:32]);
      pa_q[2] <= 64'(mod1_q[63:32]) * 64'(d2m[31:0]);
      pa_q[3] <= 64'(mod1_q[63:32]) * 64'(d2m[63:32]);
      w1_d0_q <= d0m;
      w1_d1_q <= d1m;
      y_q     <= y_d;
      w2_d0_q <= w1_d0_q;
      for (int n = 0; n < 8; n++) begin
        pp_q[n] <= 64'(mod0_q[32*(n/4) +: 32]) * 64'(y_q[32*(n%4) +: 32]);
      end
      w3_d0_q <= w2_d0_q;
      x_q     <= x_d;
    end
  end

  assign m_axis_tdata = x_q;

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("ready dropped without an output stall");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item not in first stage");

endmodule

FILE: sim/gcr_checker.sv
// checker for the garner crt unit: tracks the registers, predicts each value and compares
`timescale 1ns / 1ps
module gcr_checker #(
  parameter int unsigned PRIME_COUNT = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [199:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [255:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  output int           err_count_o,
  output int           pending_o
);

  logic [63:0]  modulus [3];
  logic [63:0]  inv_prefix [3];
  logic [255:0] value_q [$];
  int           n_err;

  assign err_count_o = n_err;
  assign pending_o   = value_q.size();

  function automatic logic [63:0] red64(logic [63:0] a, logic [63:0] m);
    return (m == 0) ? 64'd0 : a % m;
  endfunction

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    if (m < 2) return 64'd0;
    p = {64'd0, a % m} * {64'd0, b % m};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [255:0] lift_value(logic [199:0] d);
    logic [63:0]  digit [3];
    logic [63:0]  part, pm, m, r;
    logic [255:0] acc, prefix;
    int           lvl;
    lvl = d[193:192];
    if (lvl > PRIME_COUNT) lvl = PRIME_COUNT;
    for (int i = 0; i < 3; i++) digit[i] = 64'd0;
    if (lvl >= 1) digit[0] = red64(d[63:0], modulus[0]);
    for (int i = 1; i < lvl; i++) begin
      m    = modulus[i];
      part = 64'd0;
      pm   = red64(64'd1, m);
      for (int j = 0; j < i; j++) begin
        part = (m < 2) ? 64'd0 : 64'((({65'd0, part} + mulmod(digit[j], pm, m)) % {1'b0, m}));
        pm   = mulmod(pm, modulus[j], m);
      end
      r = red64(d[64*i +: 64], m);
      r = (r >= part) ? r - part : r + (m - part);
      digit[i] = mulmod(r, inv_prefix[i], m);
    end
    acc    = '0;
    prefix = 256'd1;
    for (int i = 0; i < lvl; i++) begin
      acc    = acc + prefix * {192'd0, digit[i]};
      prefix = prefix * {192'd0, modulus[i]};
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [255:0] want;
    if (!rst_ni) begin
      modulus[0]    <= 64'd2;
      modulus[1]    <= 64'd3;
      modulus[2]    <= 64'd5;
      inv_prefix[0] <= 64'd1;
      inv_prefix[1] <= 64'd2;
      inv_prefix[2] <= 64'd1;
      value_q.delete();
      n_err = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) value_q.push_back(lift_value(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (value_q.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[63:0], 64'd0);
        end else begin
          want = value_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (m_axis_tdata[64*k +: 64] !== want[64*k +: 64])
              report_mismatch($sformatf("value_limb%0d", k), m_axis_tdata[64*k +: 64],
                              want[64*k +: 64]);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          gcr_pkg::REG_MODULUS_0:    modulus[0]    <= pwdata;
          gcr_pkg::REG_MODULUS_1:    modulus[1]    <= pwdata;
          gcr_pkg::REG_MODULUS_2:    modulus[2]    <= pwdata;
          gcr_pkg::REG_INV_PREFIX_1: inv_prefix[1] <= pwdata;
          gcr_pkg::REG_INV_PREFIX_2: inv_prefix[2] <= pwdata;
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: sim/tb_garner_crt_reconstruct_unit.sv
// testbench top for the garner crt unit: stimulus, register phases and verdict
`timescale 1ns / 1ps
module tb_garner_crt_reconstruct_unit;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  int           err_count, pending;
  int           tx_idle_pct = 0, rx_idle_pct = 0;
  int           cycle = 0;
  logic [63:0]  cur_mod [3];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  garner_crt_reconstruct_unit u_top (.*);

  gcr_checker u_chk (.*, .err_count_o(err_count), .pending_o(pending));

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("tb_garner_crt_reconstruct_unit: errors");
      $finish;
    end
  end

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, a % m} * {64'd0, b % m};
    return 64'(p % {64'd0, m});
  endfunction

  // inverse modulo a prime by fermat
  function automatic logic [63:0] inv_prime(logic [63:0] a, logic [63:0] m);
    logic [63:0] r, e;
    r = 64'd1;
    e = m - 2;
    for (int i = 63; i >= 0; i--) begin
      r = mulmod(r, r, m);
      if (e[i]) r = mulmod(r, a, m);
    end
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx <= gcr_pkg::REG_MODULUS_2) cur_mod[idx[1:0]] = v;
  endtask

  task automatic set_moduli(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                            logic [63:0] i1, logic [63:0] i2);
    reg_write(gcr_pkg::REG_MODULUS_0, m0);
    reg_write(gcr_pkg::REG_MODULUS_1, m1);
    reg_write(gcr_pkg::REG_MODULUS_2, m2);
    reg_write(gcr_pkg::REG_INV_PREFIX_1, i1);
    reg_write(gcr_pkg::REG_INV_PREFIX_2, i2);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_item(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2, logic [1:0] lvl);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, lvl, r2, r1, r0};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [63:0] pick_residue(logic [63:0] m);
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return m - 1;
      3: return m;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_items(int count, int base);
    logic [1:0] lvl;
    for (int n = 0; n < count; n++) begin
      case (((base + n) * 3) / RANDOM_ITEMS)
        0: begin tx_idle_pct = 25; rx_idle_pct = 64; end
        1: begin tx_idle_pct = 64; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      lvl = ($urandom_range(0, 9) < 3) ? 2'($urandom_range(0, 2)) : 2'd3;
      send_item(pick_residue(cur_mod[0]), pick_residue(cur_mod[1]),
                pick_residue(cur_mod[2]), lvl);
    end
  endtask

  initial begin
    logic [63:0] p0, p1, p2;
    cur_mod[0] = 64'd2; cur_mod[1] = 64'd3; cur_mod[2] = 64'd5;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: every level, residue extremes
    for (int l = 0; l < 4; l++) begin
      send_item(64'd0, 64'd0, 64'd0, 2'(l));
      send_item('1, '1, '1, 2'(l));
      send_item(64'd1, 64'd2, 64'd4, 2'(l));
    end
    send_item(64'd2, 64'd3, 64'd5, 2'd3);
    send_item(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 2'd3);
    wait_drained();

    // large primes with true inverses
    p0 = 64'hFFFF_FFFF_FFFF_FFC5;
    p1 = 64'hFFFF_FFFF_FFFF_FFAD;
    p2 = 64'hFFFF_FFFF_FFFF_FFA1;
    set_moduli(p0, p1, p2, inv_prime(p0 % p1, p1), inv_prime(mulmod(p0, p1, p2), p2));
    send_item('1, '1, '1, 2'd3);
    send_item(p0 - 1, p1 - 1, p2 - 1, 2'd3);
    send_item(p0, p1, p2, 2'd3);
    random_items(450, 0);
    wait_drained();

    // degenerate moduli and raw inverse extremes
    set_moduli(64'd0, 64'd1, '1, 64'd0, '1);
    send_item('1, '1, '1, 2'd3);
    send_item(64'd5, 64'd7, 64'd9, 2'd2);
    random_items(200, 450);
    wait_drained();
    set_moduli('1, 64'd0, 64'd1, '1, 64'd0);
    random_items(200, 650);
    wait_drained();

    // random moduli and unrelated inverses
    set_moduli({$urandom, $urandom} | 64'd2, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    random_items(450, 850);
    wait_drained();

    // small primes with true inverses
    set_moduli(64'd7, 64'd11, 64'd13, inv_prime(64'd7, 64'd11), inv_prime(64'd77, 64'd13));
    random_items(450, 1300);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (400) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_garner_crt_reconstruct_unit: clean");
    end else begin
      $display("tb_garner_crt_reconstruct_unit: errors");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/gcr_pkg.sv
hdl/gcr_modred.sv
hdl/gcr_modmul.sv
hdl/garner_crt_reconstruct_unit.sv
sim/gcr_checker.sv
sim/tb_garner_crt_reconstruct_unit.sv
